### design/tsr_pkg.sv
// shared types, codes and defaults of the topic subscription router
package tsr_pkg;

  localparam int TOPIC_COUNT_DEF     = 256;
  localparam int SLOTS_PER_TOPIC_DEF = 8;
  localparam int QUEUE_DEPTH_DEF     = 16;

  localparam logic [4:0] LIMIT_RESET = 5'd10;
  localparam logic [7:0] GROUP_ALL   = 8'h00;

  localparam logic [2:0] MODE_SUB      = 3'd0;
  localparam logic [2:0] MODE_UNSUB    = 3'd1;
  localparam logic [2:0] MODE_PUB      = 3'd2;
  localparam logic [2:0] MODE_DISPATCH = 3'd3;
  localparam logic [2:0] MODE_PURGE    = 3'd4;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_DUP      = 3'd1;
  localparam logic [2:0] STS_FULL     = 3'd2;
  localparam logic [2:0] STS_QFULL    = 3'd3;
  localparam logic [2:0] STS_QEMPTY   = 3'd4;
  localparam logic [2:0] STS_NOTFOUND = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_QWAIT,
    S_PURGE,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  owner;
    logic [7:0]  group;
    logic [31:0] handler;
  } slot_entry_t;

  typedef struct packed {
    logic [15:0] topic;
    logic [31:0] payload;
    logic [15:0] size;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic can_push;
  } q_status_t;

endpackage

### design/tsr_slot_ram.sv
// subscriber slot table: one write port, one registered read port
module tsr_slot_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  tsr_pkg::slot_entry_t  wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output tsr_pkg::slot_entry_t  rd_data
);
  import tsr_pkg::*;

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/tsr_queue.sv
// publish ring: entry memory with head, tail and fill count
module tsr_queue #(
  parameter int DEPTH = 16,
  parameter int QW    = 4,
  parameter int FW    = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tsr_pkg::q_entry_t  push_data,
  input  logic               pop,
  input  logic [4:0]         limit,
  output tsr_pkg::q_entry_t  pop_data,
  output tsr_pkg::q_status_t stat
);
  import tsr_pkg::*;

  localparam int CW = (FW > 5) ? FW : 5;

  q_entry_t      mem [DEPTH];
  logic [QW-1:0] head;
  logic [QW-1:0] tail;
  logic [FW-1:0] fill;
  logic [CW-1:0] eff_limit;

  // a limit above the depth acts as the depth
  assign eff_limit     = (CW'(limit) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(limit);
  assign stat.empty    = (fill == '0);
  assign stat.can_push = (CW'(fill) < eff_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        tail <= (tail == QW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == QW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    if (pop) begin
      pop_data <= mem[head];
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> stat.can_push)
    else $error("push into a queue at its limit");
  a_pop_data: assert property (@(posedge clk) disable iff (rst) pop |-> !stat.empty)
    else $error("pop from an empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= FW'(DEPTH))
    else $error("fill count beyond depth");

endmodule

### design/topic_subscription_router_core.sv
// top level of the topic subscription router: sequencer, config register, result register
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  in       | in_valid / in_ready    | mode topic requester handler_ref payload_ref
//           |                        | payload_size
//  out      | out_valid / out_ready  | status delivered subscriber handler_out
//           |                        | event_topic event_payload event_size last
//  cfg      | cfg_we                 | cfg_wdata (queue_limit)
//
// from input transfer to result load: subscribe and unsubscribe scan the topic's slots with
// one slot table read per cycle, dispatch reads the queue entry first and then scans the
// same way, publish loads its result directly, and purge walks the whole table.
// after reset a clearing pass over all TOPIC_COUNT*SLOTS_PER_TOPIC entries holds in_ready low.
// a dispatch scan pauses while a delivery waits in the result register.
// in_ready is high in idle even while a finished result waits to transfer.
module topic_subscription_router_core #(
  parameter int TOPIC_COUNT     = tsr_pkg::TOPIC_COUNT_DEF,
  parameter int SLOTS_PER_TOPIC = tsr_pkg::SLOTS_PER_TOPIC_DEF,
  parameter int QUEUE_DEPTH     = tsr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [15:0] topic,
  input  logic [7:0]  requester,
  input  logic [31:0] handler_ref,
  input  logic [31:0] payload_ref,
  input  logic [15:0] payload_size,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        delivered,
  output logic [7:0]  subscriber,
  output logic [31:0] handler_out,
  output logic [15:0] event_topic,
  output logic [31:0] event_payload,
  output logic [15:0] event_size,
  output logic        last
);
  import tsr_pkg::*;

  localparam int TABLE = TOPIC_COUNT * SLOTS_PER_TOPIC;
  localparam int AW    = (TABLE > 1) ? $clog2(TABLE) : 1;
  localparam int PW    = $clog2(TABLE + 1);
  localparam int SW    = $clog2(SLOTS_PER_TOPIC + 1);
  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);

  fsm_t state, state_next;
  logic [4:0] queue_limit;

  logic [2:0]    op;
  logic [7:0]    req;
  logic [7:0]    grp;
  logic [31:0]   hnd;
  logic [AW-1:0] base;
  logic [SW-1:0] scan_cnt;
  logic [PW-1:0] walk_cnt;
  logic          rvalid;
  logic [AW-1:0] rd_addr_q;
  logic          dup;
  logic          free_found;
  logic [AW-1:0] free_addr;
  logic          match_found;
  logic [AW-1:0] match_addr;
  logic          held_valid;
  logic [7:0]    held_owner;
  logic [31:0]   held_handler;
  logic          any_hit;
  logic [15:0]   etopic;
  logic [31:0]   epay;
  logic [15:0]   esize;
  logic [2:0]    res_status;
  logic          res_deliv;
  logic [7:0]    res_sub;
  logic [31:0]   res_handler;
  logic          show_evt;

  logic          in_xfer;
  logic          out_free;
  logic          in_range;
  logic          q_in_range;
  logic [AW-1:0] in_base;
  logic [AW-1:0] q_base;
  logic          scan_issue;
  logic          purge_issue;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_entry_t   wr_data;
  slot_entry_t   slot_q;
  logic          hit;
  logic          stall;
  logic          proc;
  logic          scan_end;
  logic          purge_end;
  logic          emit_mid;
  logic          out_load;
  logic          q_push;
  logic          q_pop;
  q_entry_t      q_push_data;
  q_entry_t      q_pop_data;
  q_status_t     q_stat;

  assign in_ready   = (state == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign in_range   = ({1'b0, topic[7:0]} < 9'(TOPIC_COUNT));
  assign q_in_range = ({1'b0, q_pop_data.topic[7:0]} < 9'(TOPIC_COUNT));
  assign in_base    = AW'(int'(topic[7:0]) * SLOTS_PER_TOPIC);
  assign q_base     = AW'(int'(q_pop_data.topic[7:0]) * SLOTS_PER_TOPIC);

  assign hit = slot_q.active && (etopic[15:8] == GROUP_ALL || slot_q.group == etopic[15:8]);
  // a new hit can only move on once the previous one has gone to the result register
  assign stall    = (state == S_SCAN) && (op == MODE_DISPATCH) && rvalid && hit
                    && held_valid && !out_free;
  assign emit_mid = (state == S_SCAN) && (op == MODE_DISPATCH) && rvalid && hit
                    && held_valid && out_free;
  assign proc     = (state == S_SCAN) && rvalid && !stall;

  assign scan_issue  = (state == S_SCAN) && (scan_cnt != SW'(SLOTS_PER_TOPIC)) && !stall;
  assign purge_issue = (state == S_PURGE) && (walk_cnt != PW'(TABLE));
  assign scan_end    = (state == S_SCAN) && (scan_cnt == SW'(SLOTS_PER_TOPIC)) && !rvalid;
  assign purge_end   = (state == S_PURGE) && (walk_cnt == PW'(TABLE)) && !rvalid;

  assign q_push              = in_xfer && (mode == MODE_PUB) && q_stat.can_push;
  assign q_pop               = in_xfer && (mode == MODE_DISPATCH) && !q_stat.empty;
  assign q_push_data.topic   = topic;
  assign q_push_data.payload = payload_ref;
  assign q_push_data.size    = payload_size;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (walk_cnt == PW'(TABLE - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          priority case (mode)
            MODE_SUB, MODE_UNSUB: state_next = in_range ? S_SCAN : S_DONE;
            MODE_PUB:             state_next = S_DONE;
            MODE_DISPATCH:        state_next = q_stat.empty ? S_DONE : S_QWAIT;
            MODE_PURGE:           state_next = S_PURGE;
            default:              state_next = S_IDLE;
          endcase
        end
      end
      S_QWAIT: state_next = q_in_range ? S_SCAN : S_DONE;
      S_SCAN: begin
        if (scan_end) state_next = S_DONE;
      end
      S_PURGE: begin
        if (purge_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // table accesses and result loads
  always_comb begin
    rd_en    = scan_issue || purge_issue;
    rd_addr  = (state == S_PURGE) ? walk_cnt[AW-1:0] : base + AW'(scan_cnt);
    wr_en    = 1'b0;
    wr_addr  = rd_addr_q;
    wr_data  = '0;
    out_load = emit_mid || ((state == S_DONE) && out_free);
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = walk_cnt[AW-1:0];
      end
      S_PURGE: begin
        wr_en = rvalid && slot_q.active && (slot_q.owner == req);
      end
      S_SCAN: begin
        if (scan_end && op == MODE_SUB) begin
          wr_en           = !dup && free_found;
          wr_addr         = free_addr;
          wr_data.active  = 1'b1;
          wr_data.owner   = req;
          wr_data.group   = grp;
          wr_data.handler = hnd;
        end else if (scan_end && op == MODE_UNSUB) begin
          wr_en   = match_found;
          wr_addr = match_addr;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      queue_limit <= LIMIT_RESET;
      walk_cnt    <= '0;
      rvalid      <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= stall ? 1'b1 : rd_en;
      if (cfg_we) begin
        queue_limit <= cfg_wdata;
      end
      if (in_xfer) begin
        walk_cnt <= '0;
      end else if ((state == S_CLEAR) || purge_issue) begin
        walk_cnt <= walk_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (in_xfer || state == S_QWAIT) begin
      scan_cnt <= '0;
    end else if (scan_issue) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
    if (in_xfer) begin
      op          <= mode;
      req         <= requester;
      grp         <= topic[15:8];
      hnd         <= handler_ref;
      base        <= in_base;
      dup         <= 1'b0;
      free_found  <= 1'b0;
      match_found <= 1'b0;
      held_valid  <= 1'b0;
      any_hit     <= 1'b0;
      show_evt    <= 1'b0;
      res_deliv   <= 1'b0;
      res_sub     <= '0;
      res_handler <= '0;
      priority case (mode)
        MODE_PUB:      res_status <= q_stat.can_push ? STS_OK : STS_QFULL;
        MODE_DISPATCH: res_status <= q_stat.empty ? STS_QEMPTY : STS_OK;
        default:       res_status <= STS_NOTFOUND;
      endcase
    end
    if (state == S_QWAIT) begin
      etopic   <= q_pop_data.topic;
      epay     <= q_pop_data.payload;
      esize    <= q_pop_data.size;
      base     <= q_base;
      show_evt <= 1'b1;
    end
    if (proc) begin
      priority case (op)
        MODE_SUB: begin
          if (slot_q.active && slot_q.owner == req) begin
            dup <= 1'b1;
          end else if (!slot_q.active && !free_found) begin
            free_found <= 1'b1;
            free_addr  <= rd_addr_q;
          end
        end
        MODE_UNSUB: begin
          if (slot_q.active && slot_q.owner == req && slot_q.group == grp && !match_found)
          begin
            match_found <= 1'b1;
            match_addr  <= rd_addr_q;
          end
        end
        default: begin
          if (hit) begin
            held_valid   <= 1'b1;
            held_owner   <= slot_q.owner;
            held_handler <= slot_q.handler;
          end
        end
      endcase
    end
    if (scan_end) begin
      priority case (op)
        MODE_SUB:   res_status <= dup ? STS_DUP : (free_found ? STS_OK : STS_FULL);
        MODE_UNSUB: res_status <= match_found ? STS_OK : STS_NOTFOUND;
        default: begin
          res_deliv   <= held_valid;
          res_sub     <= held_valid ? held_owner : '0;
          res_handler <= held_valid ? held_handler : '0;
        end
      endcase
    end
    if (state == S_PURGE && wr_en) begin
      any_hit <= 1'b1;
    end
    if (purge_end) begin
      res_status <= any_hit ? STS_OK : STS_NOTFOUND;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (emit_mid) begin
        status        <= STS_OK;
        delivered     <= 1'b1;
        subscriber    <= held_owner;
        handler_out   <= held_handler;
        event_topic   <= etopic;
        event_payload <= epay;
        event_size    <= esize;
        last          <= 1'b0;
      end else begin
        status        <= res_status;
        delivered     <= res_deliv;
        subscriber    <= res_sub;
        handler_out   <= res_handler;
        event_topic   <= show_evt ? etopic : '0;
        event_payload <= show_evt ? epay : '0;
        event_size    <= show_evt ? esize : '0;
        last          <= 1'b1;
      end
    end
  end

  tsr_slot_ram #(
    .DEPTH (TABLE),
    .AW    (AW)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (slot_q)
  );

  tsr_queue #(
    .DEPTH (QUEUE_DEPTH),
    .QW    (QW),
    .FW    (FW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .limit     (queue_limit),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stall |=> rvalid && $stable(rd_addr_q))
    else $error("stalled slot read lost");
  a_load_free: assert property (@(posedge clk) disable iff (rst) out_load |-> out_free)
    else $error("result register overwritten");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("slot read and write to the same entry");

endmodule

### bench/tb_top.sv
// testbench for topic_subscription_router_core: directed table, random phases, self-checking
`timescale 1ns / 100ps

module tb_top;
  import tsr_pkg::*;

  localparam int TABLE_SLOTS = TOPIC_COUNT_DEF * SLOTS_PER_TOPIC_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = TABLE_SLOTS + 60;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] topic;
    logic [7:0]  requester;
    logic [31:0] handler;
    logic [31:0] payload;
    logic [15:0] size;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        delivered;
    logic [7:0]  subscriber;
    logic [31:0] handler;
    logic [15:0] topic;
    logic [31:0] payload;
    logic [15:0] size;
    logic        last;
  } event_t;

  typedef struct packed {
    request_t   req;
    logic       typed;
    logic [2:0] sts;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid, in_ready;
  logic [2:0]  mode;
  logic [15:0] topic;
  logic [7:0]  requester;
  logic [31:0] handler_ref, payload_ref;
  logic [15:0] payload_size;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        out_valid, out_ready;
  logic [2:0]  status;
  logic        delivered;
  logic [7:0]  subscriber;
  logic [31:0] handler_out;
  logic [15:0] event_topic;
  logic [31:0] event_payload;
  logic [15:0] event_size;
  logic        last;

  topic_subscription_router_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .topic(topic), .requester(requester),
    .handler_ref(handler_ref), .payload_ref(payload_ref), .payload_size(payload_size),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .delivered(delivered), .subscriber(subscriber),
    .handler_out(handler_out), .event_topic(event_topic), .event_payload(event_payload),
    .event_size(event_size), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // router model state
  logic        sub_active  [TABLE_SLOTS];
  logic [7:0]  sub_owner   [TABLE_SLOTS];
  logic [7:0]  sub_group   [TABLE_SLOTS];
  logic [31:0] sub_handler [TABLE_SLOTS];
  request_t    ring [QUEUE_DEPTH_DEF];
  int          ring_head, ring_tail, ring_fill;
  logic [4:0]  depth_limit;

  event_t    pending_events[$];
  stim_row_t stim_table[$];
  int        errors, requests_sent, events_seen, deliveries_seen;
  int        cycles;
  bit        no_idle;

  function automatic void expect_event(logic [2:0] st, logic dl, logic [7:0] sb,
                                       logic [31:0] h, request_t e, logic lst);
    event_t ev;
    ev = '{st, dl, sb, h, e.topic, e.payload, e.size, lst};
    pending_events.push_back(ev);
  endfunction

  function automatic void route_request(request_t r);
    request_t none, e;
    int base, free_slot, i, lim, n, hits[$];
    logic [7:0] grp;
    logic [2:0] st;
    logic dup;
    none = '0;
    grp = r.topic[15:8];
    base = int'(r.topic[7:0]) * SLOTS_PER_TOPIC_DEF;
    st = STS_NOTFOUND;
    case (r.mode)
      MODE_SUB: begin
        dup = 1'b0;
        free_slot = -1;
        for (i = base; i < base + SLOTS_PER_TOPIC_DEF; i++) begin
          if (sub_active[i]) begin
            if (sub_owner[i] == r.requester) dup = 1'b1;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (dup) begin
          st = STS_DUP;
        end else if (free_slot < 0) begin
          st = STS_FULL;
        end else begin
          sub_active[free_slot]  = 1'b1;
          sub_owner[free_slot]   = r.requester;
          sub_group[free_slot]   = grp;
          sub_handler[free_slot] = r.handler;
          st = STS_OK;
        end
        expect_event(st, 1'b0, 8'd0, 32'd0, none, 1'b1);
      end
      MODE_UNSUB: begin
        for (i = base; i < base + SLOTS_PER_TOPIC_DEF; i++) begin
          if (st != STS_OK && sub_active[i] && sub_owner[i] == r.requester
              && sub_group[i] == grp) begin
            sub_active[i] = 1'b0;
            st = STS_OK;
          end
        end
        expect_event(st, 1'b0, 8'd0, 32'd0, none, 1'b1);
      end
      MODE_PUB: begin
        lim = (depth_limit > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : int'(depth_limit);
        if (ring_fill < lim) begin
          ring[ring_tail] = r;
          ring_tail = (ring_tail + 1) % QUEUE_DEPTH_DEF;
          ring_fill++;
          st = STS_OK;
        end else begin
          st = STS_QFULL;
        end
        expect_event(st, 1'b0, 8'd0, 32'd0, none, 1'b1);
      end
      MODE_DISPATCH: begin
        if (ring_fill == 0) begin
          expect_event(STS_QEMPTY, 1'b0, 8'd0, 32'd0, none, 1'b1);
        end else begin
          e = ring[ring_head];
          ring_head = (ring_head + 1) % QUEUE_DEPTH_DEF;
          ring_fill--;
          base = int'(e.topic[7:0]) * SLOTS_PER_TOPIC_DEF;
          for (i = base; i < base + SLOTS_PER_TOPIC_DEF; i++)
            if (sub_active[i] && (e.topic[15:8] == GROUP_ALL || sub_group[i] == e.topic[15:8]))
              hits.push_back(i);
          n = hits.size();
          if (n == 0) expect_event(STS_OK, 1'b0, 8'd0, 32'd0, e, 1'b1);
          for (i = 0; i < n; i++)
            expect_event(STS_OK, 1'b1, sub_owner[hits[i]], sub_handler[hits[i]], e,
                         i == n - 1);
        end
      end
      MODE_PURGE: begin
        for (i = 0; i < TABLE_SLOTS; i++) begin
          if (sub_active[i] && sub_owner[i] == r.requester) begin
            sub_active[i] = 1'b0;
            st = STS_OK;
          end
        end
        expect_event(st, 1'b0, 8'd0, 32'd0, none, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // sender: optional idle burst, then hold valid until the transfer
  task automatic send_request(request_t r, logic typed, logic [2:0] sts);
    int gap;
    request_t none;
    none = '0;
    gap = (!no_idle && $urandom_range(3) == 0) ? $urandom_range(18, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= r.mode;
    topic        <= r.topic;
    requester    <= r.requester;
    handler_ref  <= r.handler;
    payload_ref  <= r.payload;
    payload_size <= r.size;
    do @(posedge clk); while (!in_ready);
    route_request(r);
    requests_sent++;
    if (typed) begin
      void'(pending_events.pop_back());
      expect_event(sts, 1'b0, 8'd0, 32'd0, none, 1'b1);
    end
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic set_depth_limit(logic [4:0] v);
    drain_events();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    depth_limit = v;
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    logic [7:0] idx_pool[5] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'hFF};
    logic [7:0] grp_pool[4] = '{8'd0, 8'd1, 8'd2, 8'hFF};
    pick = $urandom_range(99);
    if (pick < 30)      r.mode = MODE_SUB;
    else if (pick < 42) r.mode = MODE_UNSUB;
    else if (pick < 67) r.mode = MODE_PUB;
    else if (pick < 92) r.mode = MODE_DISPATCH;
    else if (pick < 96) r.mode = MODE_PURGE;
    else                r.mode = 3'($urandom_range(7, 5));
    if ($urandom_range(99) < 85)
      r.topic = {grp_pool[$urandom_range(3)], idx_pool[$urandom_range(4)]};
    else
      r.topic = 16'($urandom);
    r.requester = ($urandom_range(99) < 85) ? 8'($urandom_range(6)) : 8'($urandom);
    if (r.requester == 8'd6) r.requester = 8'hFF;
    r.handler = $urandom;
    r.payload = $urandom;
    r.size    = 16'($urandom);
    return r;
  endfunction

  // receiver with random stall bursts
  int stall_left;
  always @(posedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(4) == 0) begin
      stall_left <= $urandom_range(18, 1) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    event_t exp_ev;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("result transfer with nothing expected: status %0d", status);
        errors++;
      end else begin
        exp_ev = pending_events.pop_front();
        events_seen++;
        if (delivered) deliveries_seen++;
        if (status !== exp_ev.status) begin
          $error("status exp %0d got %0d", exp_ev.status, status); errors++;
        end
        if (delivered !== exp_ev.delivered) begin
          $error("delivered exp %0d got %0d", exp_ev.delivered, delivered); errors++;
        end
        if (subscriber !== exp_ev.subscriber) begin
          $error("subscriber exp %0h got %0h", exp_ev.subscriber, subscriber); errors++;
        end
        if (handler_out !== exp_ev.handler) begin
          $error("handler_out exp %0h got %0h", exp_ev.handler, handler_out); errors++;
        end
        if (event_topic !== exp_ev.topic) begin
          $error("event_topic exp %0h got %0h", exp_ev.topic, event_topic); errors++;
        end
        if (event_payload !== exp_ev.payload) begin
          $error("event_payload exp %0h got %0h", exp_ev.payload, event_payload); errors++;
        end
        if (event_size !== exp_ev.size) begin
          $error("event_size exp %0h got %0h", exp_ev.size, event_size); errors++;
        end
        if (last !== exp_ev.last) begin
          $error("last exp %0d got %0d", exp_ev.last, last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_row(logic [2:0] m, logic [15:0] t, logic [7:0] rq, logic [31:0] h,
                         logic [31:0] p, logic [15:0] sz, logic typed, logic [2:0] sts);
    stim_row_t row;
    row = '{'{m, t, rq, h, p, sz}, typed, sts};
    stim_table.push_back(row);
  endtask

  initial begin
    logic [4:0] phase_limit[5] = '{5'd0, 5'd1, 5'd31, 5'd7, 5'd10};
    int ph, k, i;
    errors = 0; requests_sent = 0; events_seen = 0; deliveries_seen = 0;
    no_idle = 0;
    ring_head = 0; ring_tail = 0; ring_fill = 0;
    depth_limit = LIMIT_RESET;
    for (i = 0; i < TABLE_SLOTS; i++) sub_active[i] = 1'b0;
    rst <= 1'b1; in_valid <= 1'b0; cfg_we <= 1'b0; cfg_wdata <= '0;
    mode <= '0; topic <= '0; requester <= '0;
    handler_ref <= '0; payload_ref <= '0; payload_size <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    add_row(MODE_DISPATCH, 16'h0000, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1, STS_QEMPTY);
    add_row(MODE_UNSUB, 16'h0000, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1, STS_NOTFOUND);
    add_row(MODE_PURGE, 16'h0000, 8'hFF, 32'h0, 32'h0, 16'h0, 1'b1, STS_NOTFOUND);
    add_row(MODE_SUB, 16'h0000, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1, STS_OK);
    add_row(MODE_SUB, 16'h0000, 8'h00, 32'h1, 32'h0, 16'h0, 1'b1, STS_DUP);
    for (k = 1; k <= 8; k++)
      add_row(MODE_SUB, 16'h0005, 8'(k), 32'hA000_0000 + k, 32'h0, 16'h0, 1'b1, STS_OK);
    // topic with every slot taken
    add_row(MODE_SUB, 16'h0005, 8'h09, 32'h0, 32'h0, 16'h0, 1'b1, STS_FULL);
    add_row(MODE_PUB, 16'h0005, 8'h00, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, STS_OK);
    add_row(MODE_PUB, 16'hFF00, 8'h00, 32'h0, 32'h1234_5678, 16'h0001, 1'b1, STS_OK);
    add_row(3'd5, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, STS_OK);
    add_row(3'd7, 16'h0000, 8'h00, 32'h0, 32'h0, 16'h0, 1'b0, STS_OK);
    add_row(MODE_DISPATCH, 16'h0000, 8'h00, 32'h0, 32'h0, 16'h0, 1'b0, STS_OK);
    // group mismatch: entry leaves the ring with no delivery
    add_row(MODE_DISPATCH, 16'h0000, 8'h00, 32'h0, 32'h0, 16'h0, 1'b0, STS_OK);
    add_row(MODE_UNSUB, 16'h0005, 8'h03, 32'h0, 32'h0, 16'h0, 1'b1, STS_OK);
    add_row(MODE_PURGE, 16'h0000, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1, STS_OK);
    add_row(MODE_SUB, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b1, STS_OK);
    add_row(MODE_UNSUB, 16'hFEFF, 8'hFF, 32'h0, 32'h0, 16'h0, 1'b1, STS_NOTFOUND);

    set_depth_limit(5'd16);
    foreach (stim_table[k])
      send_request(stim_table[k].req, stim_table[k].typed, stim_table[k].sts);

    for (ph = 0; ph < 5; ph++) begin
      set_depth_limit(phase_limit[ph]);
      no_idle = (ph == 4);
      for (k = 0; k < 36; k++) begin
        if (ph == 1 && k == 12) drain_events();
        send_request(random_request(), 1'b0, STS_OK);
      end
    end

    drain_events();
    repeat (60) @(posedge clk);
    if (pending_events.size() != 0) begin
      $error("%0d expected results never arrived", pending_events.size());
      errors++;
    end
    $display("%0d requests over six queue limit settings (0, 1, 7, 10, 16, 31)",
             requests_sent);
    $display("%0d results checked, %0d of them deliveries", events_seen, deliveries_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
